[rtl/assert_macros.svh]
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GCS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gear solver assertion failed");
`define GCS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("gear solver assertion failed");
`else
`define GCS_ASSERT(lbl, clk, rst_n, prop)
`define GCS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/gcs_pkg.sv]
package gcs_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic [30:0]        t_uq16;

    typedef enum logic [1:0] {
        OP_CAPTURE = 2'd0,
        OP_WARM    = 2'd1,
        OP_VEL     = 2'd2,
        OP_POS     = 2'd3
    } t_opcode;

    localparam logic [2:0] REG_GEAR_RATIO = 3'd0;
    localparam logic [2:0] REG_REF_FIRST  = 3'd1;
    localparam logic [2:0] REG_REF_SECOND = 3'd2;
    localparam logic [2:0] REG_INV_A      = 3'd3;
    localparam logic [2:0] REG_INV_B      = 3'd4;
    localparam logic [2:0] REG_INV_C      = 3'd5;
    localparam logic [2:0] REG_INV_D      = 3'd6;
    localparam logic [2:0] REG_SLOP       = 3'd7;

    localparam logic signed [31:0] Q_ONE     = 32'sh0001_0000;
    localparam logic [30:0]        SLOP_RST  = 31'd131;

    function automatic t_q16 sat_s32(input logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sx48(input logic signed [33:0] v);
        return {{14{v[33]}}, v};
    endfunction

endpackage

[rtl/gcs_in_if.sv]
interface gcs_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    gcs_pkg::t_q16        omega_a;
    gcs_pkg::t_q16        omega_b;
    gcs_pkg::t_q16        omega_c;
    gcs_pkg::t_q16        omega_d;
    gcs_pkg::t_q16        angle_a;
    gcs_pkg::t_q16        angle_b;
    gcs_pkg::t_q16        angle_c;
    gcs_pkg::t_q16        angle_d;

    modport source (output valid, opcode, omega_a, omega_b, omega_c, omega_d,
                    angle_a, angle_b, angle_c, angle_d, input ready);
    modport sink   (input valid, opcode, omega_a, omega_b, omega_c, omega_d,
                    angle_a, angle_b, angle_c, angle_d, output ready);
endinterface

[rtl/gcs_out_if.sv]
interface gcs_out_if;
    logic          valid;
    logic          ready;
    gcs_pkg::t_q16 result_a;
    gcs_pkg::t_q16 result_b;
    gcs_pkg::t_q16 result_c;
    gcs_pkg::t_q16 result_d;
    logic          converged;

    modport source (output valid, result_a, result_b, result_c, result_d, converged,
                    input ready);
    modport sink   (input valid, result_a, result_b, result_c, result_d, converged,
                    output ready);
endinterface

[rtl/gear_constraint_solver_unit.sv]
// operations: capture, velocity solve, warm start and position pass; the
// position pass runs up to 9 bit-serial multiplies plus one restoring division
// throughput: one transfer at a time; the next item is taken once the
// result sits in the output register; reset is synchronous, active low,
// and restores the register defaults and clears the solver state
`include "assert_macros.svh"

module gear_constraint_solver_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gcs_in_if.sink           i_item,
    gcs_out_if.source        o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [4:0] PC_APPLY = 5'd16;

    // configuration
    gcs_pkg::t_q16  r_ratio, r_ref1, r_ref2;
    gcs_pkg::t_uq16 r_ia, r_ib, r_ic, r_id, r_slop;
    // solver state
    gcs_pkg::t_q16  r_gc, r_acc, n_gc, n_acc;
    gcs_pkg::t_uq16 r_em, n_em;

    t_state r_state, n_state;
    logic [4:0] r_pc, n_pc;
    logic [1:0] r_op;
    gcs_pkg::t_q16 r_wa, r_wb, r_wc, r_wd, r_aa, r_ab, r_ac, r_ad;

    gcs_pkg::t_q16 r_t0, r_t1, r_t2, r_imp, n_t0, n_t1, n_t2, n_imp;
    logic [33:0] r_m, n_m;
    logic r_neg, n_neg;
    gcs_pkg::t_q16 r_ra, r_rb, r_rc, r_rd, n_ra, n_rb, n_rc, n_rd;
    logic r_conv, n_conv;

    // bit-serial multiplier
    logic signed [31:0] r_ma, n_ma;
    logic signed [32:0] r_mh, n_mh;
    logic [31:0] r_ml, n_ml;
    logic [4:0] r_mcnt, n_mcnt;
    // restoring divider, one quotient bit per cycle
    logic [47:0] r_dn, n_dn;
    logic [33:0] r_dr, n_dr, r_dd, n_dd;
    logic [5:0] r_dcnt, n_dcnt;

    logic r_ovalid;
    gcs_pkg::t_q16 r_oa, r_ob, r_oc, r_od;
    logic r_oconv;

    logic signed [63:0] w_prod;
    gcs_pkg::t_q16 w_mr;
    logic signed [33:0] w_aext, w_hext, w_msum;
    logic [34:0] w_rsh;
    logic [35:0] w_trial;
    logic [31:0] w_absc;
    logic w_cfg_wr;
    logic w_load_out;

    assign w_prod = {r_mh[31:0], r_ml};
    assign w_mr   = gcs_pkg::sat_s32(w_prod[63:16]);
    assign w_aext = {{2{r_ma[31]}}, r_ma};
    assign w_hext = {r_mh[32], r_mh};
    // last multiplier bit carries negative weight
    assign w_msum = (r_mcnt == 5'd31) ? (w_hext - (r_ml[0] ? w_aext : 34'sd0))
                                      : (w_hext + (r_ml[0] ? w_aext : 34'sd0));
    assign w_rsh   = {r_dr, r_dn[47]};
    assign w_trial = {1'b0, w_rsh} - {2'b00, r_dd};
    assign w_absc  = r_t0[31] ? (32'd0 - r_t0) : r_t0;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_load_out   = (r_state == S_DONE) && (!r_ovalid || o_result.ready);

    always_comb begin
        n_state = r_state;  n_pc = r_pc;
        n_gc = r_gc;  n_acc = r_acc;  n_em = r_em;
        n_t0 = r_t0;  n_t1 = r_t1;  n_t2 = r_t2;  n_imp = r_imp;
        n_m = r_m;  n_neg = r_neg;
        n_ra = r_ra;  n_rb = r_rb;  n_rc = r_rc;  n_rd = r_rd;  n_conv = r_conv;
        n_ma = r_ma;  n_mh = r_mh;  n_ml = r_ml;  n_mcnt = r_mcnt;
        n_dn = r_dn;  n_dr = r_dr;  n_dd = r_dd;  n_dcnt = r_dcnt;

        unique case (r_state)
            S_IDLE: begin
                if (i_item.valid) begin
                    n_state = S_EXEC;
                    n_pc = 5'd0;
                    n_ra = '0;  n_rb = '0;  n_rc = '0;  n_rd = '0;  n_conv = 1'b0;
                end
            end
            S_MUL: begin
                n_mh = w_msum[33:1];
                n_ml = {w_msum[0], r_ml[31:1]};
                n_mcnt = r_mcnt + 5'd1;
                if (r_mcnt == 5'd31) begin
                    n_state = S_EXEC;
                end
            end
            S_DIV: begin
                if (!w_trial[35]) begin
                    n_dr = w_trial[33:0];
                end else begin
                    n_dr = w_rsh[33:0];
                end
                n_dn = {r_dn[46:0], !w_trial[35]};
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd47) begin
                    n_state = S_EXEC;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                n_pc = r_pc + 5'd1;
                if (r_pc >= PC_APPLY) begin
                    // shared tail: per-body impulse, velocity update or correction
                    unique case (r_pc)
                        5'd16: begin
                            n_ma = {1'b0, r_ia};  n_ml = r_imp;
                        end
                        5'd17: begin
                            n_ra = (r_op == gcs_pkg::OP_POS) ? w_mr
                                 : gcs_pkg::sat_s32(gcs_pkg::sx48({{2{r_wa[31]}}, r_wa} +
                                                                  {{2{w_mr[31]}}, w_mr}));
                            n_ma = {1'b0, r_ib};  n_ml = r_imp;
                        end
                        5'd18: begin
                            n_ma = w_mr;  n_ml = r_ratio;
                        end
                        5'd19: begin
                            n_rb = (r_op == gcs_pkg::OP_POS) ? w_mr
                                 : gcs_pkg::sat_s32(gcs_pkg::sx48({{2{r_wb[31]}}, r_wb} +
                                                                  {{2{w_mr[31]}}, w_mr}));
                            n_ma = (r_op == gcs_pkg::OP_POS) ? (32'sd0 - {1'b0, r_ic})
                                                             : {1'b0, r_ic};
                            n_ml = r_imp;
                        end
                        5'd20: begin
                            n_rc = (r_op == gcs_pkg::OP_POS) ? w_mr
                                 : gcs_pkg::sat_s32(gcs_pkg::sx48({{2{r_wc[31]}}, r_wc} -
                                                                  {{2{w_mr[31]}}, w_mr}));
                            n_ma = (r_op == gcs_pkg::OP_POS) ? (32'sd0 - {1'b0, r_id})
                                                             : {1'b0, r_id};
                            n_ml = r_imp;
                        end
                        5'd21: begin
                            n_ma = w_mr;  n_ml = r_ratio;
                        end
                        default: begin
                            n_rd = (r_op == gcs_pkg::OP_POS) ? w_mr
                                 : gcs_pkg::sat_s32(gcs_pkg::sx48({{2{r_wd[31]}}, r_wd} -
                                                                  {{2{w_mr[31]}}, w_mr}));
                        end
                    endcase
                    if (r_pc == 5'd22) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                    end
                end else begin
                    unique case (r_op)
                        gcs_pkg::OP_CAPTURE, gcs_pkg::OP_POS: begin
                            unique case (r_pc)
                                5'd0: begin
                                    n_t0 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_aa[31]}}, r_aa} - {{2{r_ac[31]}}, r_ac} -
                                        {{2{r_ref1[31]}}, r_ref1}));
                                    n_t1 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_ab[31]}}, r_ab} - {{2{r_ad[31]}}, r_ad} -
                                        {{2{r_ref2[31]}}, r_ref2}));
                                end
                                5'd1: begin
                                    n_ma = r_ratio;  n_ml = r_t1;
                                    n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                end
                                5'd2: begin
                                    n_t0 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_t0[31]}}, r_t0} + {{2{w_mr[31]}}, w_mr}));
                                    if (r_op == gcs_pkg::OP_CAPTURE) begin
                                        n_gc = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                            {{2{r_t0[31]}}, r_t0} + {{2{w_mr[31]}}, w_mr}));
                                        n_state = S_DONE;
                                    end else begin
                                        n_t2 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                            {3'b000, r_ib} + {3'b000, r_id}));
                                        n_ma = r_ratio;  n_ml = r_ratio;
                                        n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                    end
                                end
                                5'd3: begin
                                    // position error against the captured constant
                                    n_t0 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_t0[31]}}, r_t0} - {{2{r_gc[31]}}, r_gc}));
                                    n_ma = w_mr;  n_ml = r_t2;
                                    n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                end
                                5'd4: begin
                                    n_m = {3'b000, r_ia} + {3'b000, r_ic} +
                                          {3'b000, (w_mr[31] ? 31'd0 : w_mr[30:0])};
                                    n_conv = ({1'b0, w_absc} < {2'b00, r_slop});
                                    n_neg = !r_t0[31] && (r_t0 != 32'sd0);
                                    if (n_m == 34'd0) begin
                                        n_imp = '0;  n_pc = PC_APPLY;
                                    end else begin
                                        n_dn = {w_absc, 16'd0};  n_dr = '0;  n_dd = n_m;
                                        n_dcnt = '0;  n_state = S_DIV;
                                    end
                                end
                                default: begin
                                    if (r_neg) begin
                                        n_imp = (r_dn > 48'h0000_7FFF_FFFF) ? 32'sh8000_0000
                                                : (32'sd0 - r_dn[31:0]);
                                    end else begin
                                        n_imp = (r_dn > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                : r_dn[31:0];
                                    end
                                    n_pc = PC_APPLY;
                                end
                            endcase
                        end
                        gcs_pkg::OP_WARM: begin
                            unique case (r_pc)
                                5'd0: begin
                                    n_t2 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {3'b000, r_ib} + {3'b000, r_id}));
                                    n_imp = r_acc;
                                    n_ma = r_ratio;  n_ml = r_ratio;
                                    n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                end
                                5'd1: begin
                                    n_ma = w_mr;  n_ml = r_t2;
                                    n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                end
                                5'd2: begin
                                    n_m = {3'b000, r_ia} + {3'b000, r_ic} +
                                          {3'b000, (w_mr[31] ? 31'd0 : w_mr[30:0])};
                                    if (n_m == 34'd0) begin
                                        n_em = '0;  n_pc = PC_APPLY;
                                    end else begin
                                        n_dn = 48'h0001_0000_0000;  n_dr = '0;  n_dd = n_m;
                                        n_dcnt = '0;  n_state = S_DIV;
                                    end
                                end
                                default: begin
                                    n_em = (r_dn > 48'h0000_7FFF_FFFF) ? 31'h7FFF_FFFF
                                           : r_dn[30:0];
                                    n_pc = PC_APPLY;
                                end
                            endcase
                        end
                        default: begin
                            unique case (r_pc)
                                5'd0: begin
                                    n_t0 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_wa[31]}}, r_wa} - {{2{r_wc[31]}}, r_wc}));
                                    n_t1 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_wb[31]}}, r_wb} - {{2{r_wd[31]}}, r_wd}));
                                end
                                5'd1: begin
                                    n_ma = r_ratio;  n_ml = r_t1;
                                    n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                end
                                5'd2: begin
                                    n_t0 = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_t0[31]}}, r_t0} + {{2{w_mr[31]}}, w_mr}));
                                end
                                5'd3: begin
                                    n_ma = 32'sd0 - {1'b0, r_em};  n_ml = r_t0;
                                    n_state = S_MUL;  n_mh = '0;  n_mcnt = '0;
                                end
                                default: begin
                                    n_imp = w_mr;
                                    n_acc = gcs_pkg::sat_s32(gcs_pkg::sx48(
                                        {{2{r_acc[31]}}, r_acc} + {{2{w_mr[31]}}, w_mr}));
                                    n_pc = PC_APPLY;
                                end
                            endcase
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_comb begin
        unique case (paddr[4:2])
            gcs_pkg::REG_GEAR_RATIO: prdata = r_ratio;
            gcs_pkg::REG_REF_FIRST:  prdata = r_ref1;
            gcs_pkg::REG_REF_SECOND: prdata = r_ref2;
            gcs_pkg::REG_INV_A:      prdata = {1'b0, r_ia};
            gcs_pkg::REG_INV_B:      prdata = {1'b0, r_ib};
            gcs_pkg::REG_INV_C:      prdata = {1'b0, r_ic};
            gcs_pkg::REG_INV_D:      prdata = {1'b0, r_id};
            default:                 prdata = {1'b0, r_slop};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= gcs_pkg::Q_ONE;
            r_ref1 <= '0;  r_ref2 <= '0;
            r_ia <= '0;  r_ib <= '0;  r_ic <= '0;  r_id <= '0;
            r_slop <= gcs_pkg::SLOP_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                gcs_pkg::REG_GEAR_RATIO: r_ratio <= pwdata;
                gcs_pkg::REG_REF_FIRST:  r_ref1 <= pwdata;
                gcs_pkg::REG_REF_SECOND: r_ref2 <= pwdata;
                gcs_pkg::REG_INV_A:      r_ia <= pwdata[30:0];
                gcs_pkg::REG_INV_B:      r_ib <= pwdata[30:0];
                gcs_pkg::REG_INV_C:      r_ic <= pwdata[30:0];
                gcs_pkg::REG_INV_D:      r_id <= pwdata[30:0];
                default:                 r_slop <= pwdata[30:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gc <= '0;  r_acc <= '0;  r_em <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_gc <= n_gc;  r_acc <= n_acc;  r_em <= n_em;
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pc <= n_pc;
        r_t0 <= n_t0;  r_t1 <= n_t1;  r_t2 <= n_t2;  r_imp <= n_imp;
        r_m <= n_m;  r_neg <= n_neg;
        r_ra <= n_ra;  r_rb <= n_rb;  r_rc <= n_rc;  r_rd <= n_rd;  r_conv <= n_conv;
        r_ma <= n_ma;  r_mh <= n_mh;  r_ml <= n_ml;  r_mcnt <= n_mcnt;
        r_dn <= n_dn;  r_dr <= n_dr;  r_dd <= n_dd;  r_dcnt <= n_dcnt;
        if (i_item.valid && i_item.ready) begin
            r_op <= i_item.opcode;
            r_wa <= i_item.omega_a;  r_wb <= i_item.omega_b;
            r_wc <= i_item.omega_c;  r_wd <= i_item.omega_d;
            r_aa <= i_item.angle_a;  r_ab <= i_item.angle_b;
            r_ac <= i_item.angle_c;  r_ad <= i_item.angle_d;
        end
        if (w_load_out) begin
            r_oa <= r_ra;  r_ob <= r_rb;  r_oc <= r_rc;  r_od <= r_rd;
            r_oconv <= r_conv;
        end
    end

    assign o_result.valid     = r_ovalid;
    assign o_result.result_a  = r_oa;
    assign o_result.result_b  = r_ob;
    assign o_result.result_c  = r_oc;
    assign o_result.result_d  = r_od;
    assign o_result.converged = r_oconv;

    `GCS_ASSERT(a_accept_starts, i_clk, i_rst_n,
        (i_item.valid && i_item.ready) |=> (r_state == S_EXEC))
    `GCS_ASSERT(a_out_drop_on_transfer, i_clk, i_rst_n,
        $fell(r_ovalid) |-> $past(o_result.ready))
    `GCS_ASSERT(a_div_only_mass_ops, i_clk, i_rst_n,
        (r_state == S_DIV) |-> (r_op == gcs_pkg::OP_WARM || r_op == gcs_pkg::OP_POS))
    `GCS_ASSERT(a_mul_runs_full, i_clk, i_rst_n,
        (r_state == S_MUL && r_mcnt != 5'd31) |=> (r_state == S_MUL))

endmodule
